// File: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and word layouts of the best-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int unsigned AddrBits       = 31;
  localparam int unsigned StampBits      = 16;
  localparam int unsigned SlotBits       = 16;
  localparam int unsigned ResBits        = 32;
  localparam int unsigned HistDepthDef   = 1024;
  localparam int unsigned FreeEntriesDef = 1024;
  localparam int unsigned CmdQueueDepth  = 2;

  localparam logic [AddrBits-1:0]       MemSizeRst = AddrBits'(1024);
  localparam logic signed [ResBits-1:0] Reject     = '1;

  // front to back command kinds
  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,  // history full, answer -1, no state change
    CMD_ZERO   = 2'd1,  // zero length, slot filled as failed
    CMD_ALLOC  = 2'd2,
    CMD_REL    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [AddrBits-1:0]   amount;
    logic [SlotBits-1:0]   slot;     // history slot this item fills
    logic [SlotBits-1:0]   hist;     // slot named by a release
    logic                  rel_ok;   // release number in range
    logic                  slot_ok;  // release fills a slot
  } cmd_t;

  typedef struct packed {
    logic                  used;
    logic [StampBits-1:0]  stamp;
    logic [AddrBits-1:0]   start;
    logic [AddrBits-1:0]   len;
  } free_word_t;

  typedef struct packed {
    logic                  live;
    logic [AddrBits-1:0]   start;
    logic [AddrBits-1:0]   len;
  } grant_word_t;

  typedef enum logic [1:0] {
    SM_ALLOC = 2'd0,
    SM_REL   = 2'd1,
    SM_RENUM = 2'd2
  } scan_mode_e;

endpackage

`default_nettype wire

// File: rtl/bfa_if.sv
// ----------------------------------------------------------------------------
// bfa_if
// Valid/ready channel interfaces: request, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_req_if;
  import bfa_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [AddrBits-1:0] amount;
  modport source (output valid, op, amount, input ready);
  modport sink   (input valid, op, amount, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ResBits-1:0]  start_address;
  modport source (output valid, start_address, input ready);
  modport sink   (input valid, start_address, output ready);
endinterface

interface bfa_cfg_if;
  import bfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [AddrBits-1:0] memory_size;
  modport source (output valid, memory_size, input ready);
  modport sink   (input valid, memory_size, output ready);
endinterface

`default_nettype wire

// File: rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/bfa_fifo.sv
// ----------------------------------------------------------------------------
// bfa_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             flush_i,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_ready_i,
  output      logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (flush_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bfa_front.sv
// ----------------------------------------------------------------------------
// bfa_front
// Accepts requests, tracks history slots and classifies each item.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_front #(
  parameter int unsigned HistDepth = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         init_i,
  input  wire logic                         clearing_i,
  input  wire logic                         req_valid_i,
  output      logic                         req_ready_o,
  input  wire logic                         op_i,
  input  wire logic [bfa_pkg::AddrBits-1:0] amount_i,
  output      logic                         cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output      bfa_pkg::cmd_t                cmd_o
);
  import bfa_pkg::*;

  localparam int unsigned RcW = $clog2(HistDepth + 1);

  logic [RcW-1:0] rc_q;
  logic           full;
  logic           accept;

  assign full        = (rc_q == RcW'(HistDepth));
  assign req_ready_o = cmd_ready_i && !clearing_i;
  assign cmd_valid_o = req_valid_i && !clearing_i;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.amount  = amount_i;
    cmd_o.slot    = SlotBits'(rc_q);
    cmd_o.hist    = SlotBits'(amount_i - 1'b1);
    cmd_o.rel_ok  = (amount_i != '0) && (amount_i <= AddrBits'(rc_q));
    cmd_o.slot_ok = !full;
    if (op_i) begin
      cmd_o.kind = CMD_REL;
    end else if (full) begin
      cmd_o.kind = CMD_REJECT;
    end else if (amount_i == '0) begin
      cmd_o.kind = CMD_ZERO;
    end else begin
      cmd_o.kind = CMD_ALLOC;
    end
  end

  // every accepted item fills a slot until the history is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
    end else if (init_i) begin
      rc_q <= '0;
    end else if (accept && !full) begin
      rc_q <= rc_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bfa_back.sv
// ----------------------------------------------------------------------------
// bfa_back
// Execution engine: free table and grant table scans, updates, results.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_back #(
  parameter int unsigned FreeEntries = 1024,
  parameter int unsigned HistDepth   = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            init_i,
  input  wire logic [bfa_pkg::AddrBits-1:0]    mem_size_i,
  input  wire logic                            cmd_valid_i,
  output      logic                            cmd_ready_o,
  input  wire bfa_pkg::cmd_t                   cmd_i,
  output      logic                            clearing_o,
  output      logic                            rsp_valid_o,
  input  wire logic                            rsp_ready_i,
  output      logic signed [bfa_pkg::ResBits-1:0] rsp_data_o
);
  import bfa_pkg::*;

  localparam int unsigned FiW  = $clog2(FreeEntries);
  localparam int unsigned FcW  = $clog2(FreeEntries + 1);
  localparam int unsigned HiW  = $clog2(HistDepth);
  localparam int unsigned ClrN = (FreeEntries > HistDepth) ? FreeEntries : HistDepth;
  localparam int unsigned CcW  = $clog2(ClrN);
  localparam int unsigned FwW  = $bits(free_word_t);
  localparam int unsigned GwW  = $bits(grant_word_t);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_GRD   = 10'b0000000100,
    ST_GCHK  = 10'b0000001000,
    ST_SCAN  = 10'b0000010000,
    ST_ENTER = 10'b0000100000,
    ST_RNWR  = 10'b0001000000,
    ST_GW1   = 10'b0010000000,
    ST_GW2   = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_e;

  state_e               state_q, state_d;
  logic [CcW-1:0]       clr_q;
  logic [StampBits:0]   ctr_q;
  cmd_t                 cmd_q;
  scan_mode_e           mode_q;
  logic [FcW-1:0]       ptr_q;
  logic                 rv_q;
  logic [FiW-1:0]       rix_q;

  logic                 bf_found_q;
  logic [FiW-1:0]       bf_idx_q;
  logic [AddrBits-1:0]  bf_start_q, bf_len_q;
  logic [StampBits-1:0] bf_stamp_q;

  logic                 li_found_q, ri_found_q, uk_found_q;
  logic [FiW-1:0]       li_idx_q, ri_idx_q, uk_idx_q;
  logic [AddrBits-1:0]  li_start_q, li_len_q, ri_len_q;

  logic                 rn_found_q, have_prev_q;
  logic [FiW-1:0]       rn_idx_q;
  logic [StampBits-1:0] rn_stamp_q, rank_q, prev_q;
  logic [AddrBits-1:0]  rn_start_q, rn_len_q;

  logic [AddrBits-1:0]  s_q, l_q;
  logic [AddrBits:0]    spl_q;
  logic [FiW-1:0]       ek_q;
  logic [AddrBits-1:0]  es_q, el_q;

  logic                 gw1_en_q, g2en_q, emit_q;
  logic [HiW-1:0]       ga1_q;
  grant_word_t          gd1_q;
  logic signed [ResBits-1:0] res_q;
  logic                 rsp_valid_q;
  logic signed [ResBits-1:0] rsp_data_q;

  logic                 f_we, g_we;
  logic [FiW-1:0]       f_waddr;
  logic [HiW-1:0]       g_waddr;
  free_word_t           f_wdata, f_rd;
  grant_word_t          g_wdata, g_rd;
  logic [FwW-1:0]       f_rdata;
  logic [GwW-1:0]       g_rdata;

  logic                 scan_done, clr_last, out_free;
  logic [AddrBits:0]    end_sum;

  bfa_ram #(.Width(FwW), .Depth(FreeEntries)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (ptr_q[FiW-1:0]),
    .rdata_o (f_rdata)
  );

  bfa_ram #(.Width(GwW), .Depth(HistDepth)) u_grant_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (cmd_q.hist[HiW-1:0]),
    .rdata_o (g_rdata)
  );

  assign f_rd        = free_word_t'(f_rdata);
  assign g_rd        = grant_word_t'(g_rdata);
  assign scan_done   = (state_q == ST_SCAN) && (ptr_q == FcW'(FreeEntries)) && !rv_q;
  assign clr_last    = (clr_q == CcW'(ClrN - 1));
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign end_sum     = {1'b0, f_rd.start} + {1'b0, f_rd.len};
  assign clearing_o  = (state_q == ST_CLEAR);
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_data_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_REJECT: state_d = ST_EMIT;
            CMD_ZERO:   state_d = ST_GW1;
            CMD_ALLOC:  state_d = ST_SCAN;
            CMD_REL:    state_d = cmd_i.rel_ok ? ST_GRD : ST_GW1;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_GRD:  state_d = ST_GCHK;
      ST_GCHK: state_d = g_rd.live ? ST_SCAN : ST_GW1;
      ST_SCAN: begin
        if (scan_done) begin
          unique case (mode_q)
            SM_ALLOC: begin
              if (bf_found_q && (bf_len_q != cmd_q.amount)) state_d = ST_ENTER;
              else                                            state_d = ST_GW1;
            end
            SM_REL: begin
              if (li_found_q || ri_found_q || uk_found_q) state_d = ST_ENTER;
              else                                        state_d = ST_GW1;
            end
            SM_RENUM: state_d = rn_found_q ? ST_RNWR : ST_ENTER;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ENTER: state_d = ctr_q[StampBits] ? ST_SCAN : ST_GW1;
      ST_RNWR:  state_d = ST_SCAN;
      ST_GW1:   state_d = ST_GW2;
      ST_GW2:   state_d = emit_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // ---------------- table write ports ----------------
  always_comb begin
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        f_we    = (32'(clr_q) < FreeEntries);
        f_waddr = FiW'(clr_q);
        if ((clr_q == '0) && (mem_size_i != '0)) begin
          f_wdata.used  = 1'b1;
          f_wdata.start = AddrBits'(1);
          f_wdata.len   = mem_size_i;
        end
        g_we    = (32'(clr_q) < HistDepth);
        g_waddr = HiW'(clr_q);
      end
      ST_SCAN: begin
        // exact fit drops the entry; a two-sided merge drops the right one
        if (scan_done && (mode_q == SM_ALLOC) && bf_found_q &&
            (bf_len_q == cmd_q.amount)) begin
          f_we    = 1'b1;
          f_waddr = bf_idx_q;
        end else if (scan_done && (mode_q == SM_REL) && li_found_q && ri_found_q) begin
          f_we    = 1'b1;
          f_waddr = ri_idx_q;
        end
      end
      ST_ENTER: begin
        f_we          = !ctr_q[StampBits];
        f_waddr       = ek_q;
        f_wdata.used  = 1'b1;
        f_wdata.stamp = ctr_q[StampBits-1:0];
        f_wdata.start = es_q;
        f_wdata.len   = el_q;
      end
      ST_RNWR: begin
        f_we          = 1'b1;
        f_waddr       = rn_idx_q;
        f_wdata.used  = 1'b1;
        f_wdata.stamp = rank_q;
        f_wdata.start = rn_start_q;
        f_wdata.len   = rn_len_q;
      end
      ST_GW1: begin
        g_we    = gw1_en_q;
        g_waddr = ga1_q;
        g_wdata = gd1_q;
      end
      ST_GW2: begin
        g_we    = g2en_q;
        g_waddr = HiW'(cmd_q.slot);
      end
      default: ;
    endcase
  end

  // ---------------- control and scan registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ctr_q       <= (StampBits+1)'(1);
      rv_q        <= 1'b0;
      ptr_q       <= '0;
      mode_q      <= SM_ALLOC;
      rsp_valid_q <= 1'b0;
    end else if (init_i) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ctr_q   <= (StampBits+1)'(1);
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_SCAN) begin
        rv_q  <= (ptr_q != FcW'(FreeEntries));
        if (ptr_q != FcW'(FreeEntries)) begin
          ptr_q <= ptr_q + 1'b1;
        end
      end else begin
        rv_q <= 1'b0;
      end
      // a new scan starts whenever the next state is a scan entered fresh
      if ((state_d == ST_SCAN) && (state_q != ST_SCAN)) begin
        ptr_q <= '0;
      end
      if ((state_q == ST_IDLE) && cmd_valid_i) begin
        mode_q <= (cmd_i.kind == CMD_REL) ? SM_REL : SM_ALLOC;
      end
      if ((state_q == ST_ENTER) && ctr_q[StampBits]) begin
        mode_q <= SM_RENUM;
      end
      if (scan_done && (mode_q == SM_RENUM) && !rn_found_q) begin
        ctr_q <= {1'b0, rank_q};
      end
      if ((state_q == ST_ENTER) && !ctr_q[StampBits]) begin
        ctr_q <= ctr_q + 1'b1;
      end
      if ((state_q == ST_EMIT) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    rix_q <= ptr_q[FiW-1:0];
    if ((state_d == ST_SCAN) && (state_q != ST_SCAN)) begin
      bf_found_q <= 1'b0;
      li_found_q <= 1'b0;
      ri_found_q <= 1'b0;
      uk_found_q <= 1'b0;
      rn_found_q <= 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q    <= cmd_i;
          ga1_q    <= HiW'(cmd_i.slot);
          gd1_q    <= '0;
          gw1_en_q <= (cmd_i.kind == CMD_ZERO);
          g2en_q   <= (cmd_i.kind == CMD_REL) && cmd_i.slot_ok;
          emit_q   <= (cmd_i.kind != CMD_REL);
          res_q    <= Reject;
        end
      end
      ST_GCHK: begin
        s_q      <= g_rd.start;
        l_q      <= g_rd.len;
        spl_q    <= {1'b0, g_rd.start} + {1'b0, g_rd.len};
        ga1_q    <= HiW'(cmd_q.hist);
        gd1_q    <= '0;
        gw1_en_q <= g_rd.live;
      end
      ST_SCAN: begin
        if (rv_q) begin
          unique case (mode_q)
            SM_ALLOC: begin
              if (f_rd.used && (f_rd.len >= cmd_q.amount) &&
                  (!bf_found_q || (f_rd.len < bf_len_q) ||
                   ((f_rd.len == bf_len_q) && (f_rd.stamp < bf_stamp_q)))) begin
                bf_found_q <= 1'b1;
                bf_idx_q   <= rix_q;
                bf_start_q <= f_rd.start;
                bf_len_q   <= f_rd.len;
                bf_stamp_q <= f_rd.stamp;
              end
            end
            SM_REL: begin
              if (f_rd.used && (end_sum == {1'b0, s_q})) begin
                li_found_q <= 1'b1;
                li_idx_q   <= rix_q;
                li_start_q <= f_rd.start;
                li_len_q   <= f_rd.len;
              end
              if (f_rd.used && ({1'b0, f_rd.start} == spl_q)) begin
                ri_found_q <= 1'b1;
                ri_idx_q   <= rix_q;
                ri_len_q   <= f_rd.len;
              end
              if (!f_rd.used && !uk_found_q) begin
                uk_found_q <= 1'b1;
                uk_idx_q   <= rix_q;
              end
            end
            SM_RENUM: begin
              // next oldest stamp above the last one renumbered
              if (f_rd.used && (rix_q != ek_q) &&
                  (!have_prev_q || (f_rd.stamp > prev_q)) &&
                  (!rn_found_q || (f_rd.stamp < rn_stamp_q))) begin
                rn_found_q <= 1'b1;
                rn_idx_q   <= rix_q;
                rn_stamp_q <= f_rd.stamp;
                rn_start_q <= f_rd.start;
                rn_len_q   <= f_rd.len;
              end
            end
            default: ;
          endcase
        end
        if (scan_done) begin
          unique case (mode_q)
            SM_ALLOC: begin
              gw1_en_q <= 1'b1;
              if (bf_found_q) begin
                res_q       <= ResBits'(bf_start_q);
                gd1_q.live  <= 1'b1;
                gd1_q.start <= bf_start_q;
                gd1_q.len   <= cmd_q.amount;
                ek_q        <= bf_idx_q;
                es_q        <= bf_start_q + cmd_q.amount;
                el_q        <= bf_len_q - cmd_q.amount;
              end
            end
            SM_REL: begin
              if (li_found_q && ri_found_q) begin
                ek_q <= li_idx_q;
                es_q <= li_start_q;
                el_q <= li_len_q + l_q + ri_len_q;
              end else if (ri_found_q) begin
                ek_q <= ri_idx_q;
                es_q <= s_q;
                el_q <= ri_len_q + l_q;
              end else if (li_found_q) begin
                ek_q <= li_idx_q;
                es_q <= li_start_q;
                el_q <= li_len_q + l_q;
              end else begin
                // no neighbor: a free entry takes the block; with the table full it stays granted
                ek_q     <= uk_idx_q;
                es_q     <= s_q;
                el_q     <= l_q;
                gw1_en_q <= uk_found_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ENTER: begin
        if (ctr_q[StampBits]) begin
          rank_q      <= '0;
          have_prev_q <= 1'b0;
        end
      end
      ST_RNWR: begin
        rank_q      <= rank_q + 1'b1;
        prev_q      <= rn_stamp_q;
        have_prev_q <= 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          rsp_data_q <= res_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/best_fit_allocator_coalescing.sv
// ----------------------------------------------------------------------------
// best_fit_allocator_coalescing
// Best-fit free-list allocator with release and neighbor coalescing.
// ----------------------------------------------------------------------------
// Channel  | Dir | Transfer when   | Payload
// req_i    | in  | valid && ready  | op (0 alloc, 1 release), amount
// rsp_o    | out | valid && ready  | start_address (-1 on reject), allocs only
// cfg_i    | in  | valid && ready  | memory_size, re-initializes the block
//
// The time of an allocate and of a release is set by one linear pass over
// the free table RAM. A stamp renumbering adds a further pass for each of
// the k free blocks and one more; it occurs when the 16-bit stamp counter
// runs out, and it restarts the stamps at k.
// After reset and after each memory_size write the tables are cleared,
// during which req_i is not ready.
// The front accepts and classifies items into a two-entry queue while the
// back works; a stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_allocator_coalescing #(
  parameter int unsigned HISTORY_DEPTH = bfa_pkg::HistDepthDef,
  parameter int unsigned FREE_ENTRIES  = bfa_pkg::FreeEntriesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bfa_req_if.sink    req_i,
  bfa_rsp_if.source  rsp_o,
  bfa_cfg_if.sink    cfg_i
);
  import bfa_pkg::*;

  localparam int unsigned CmdW = $bits(cmd_t);

  logic [AddrBits-1:0] mem_size_q;
  logic                init;
  logic                clearing;

  // front -> queue
  logic                fq_valid, fq_ready;
  cmd_t                fq_cmd;
  // queue -> back
  logic                qb_valid, qb_ready;
  logic [CmdW-1:0]     qb_bits;

  // config always taken; a write restarts the table clear
  assign cfg_i.ready = 1'b1;
  assign init        = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MemSizeRst;
    end else if (init) begin
      mem_size_q <= cfg_i.memory_size;
    end
  end

  bfa_front #(.HistDepth(HISTORY_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (init),
    .clearing_i  (clearing),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .op_i        (req_i.op),
    .amount_i    (req_i.amount),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  bfa_fifo #(.Width(CmdW), .Depth(CmdQueueDepth)) u_cmd_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (init),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_bits)
  );

  bfa_back #(.FreeEntries(FREE_ENTRIES), .HistDepth(HISTORY_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_i      (init),
    .mem_size_i  (mem_size_q),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (cmd_t'(qb_bits)),
    .clearing_o  (clearing),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.start_address)
  );

endmodule

`default_nettype wire

// File: rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level assertions for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [31:0] rsp_addr_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_addr_i))
    else $error("result changed while stalled");

  // tables are being cleared right after a size write
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !(req_valid_i && req_ready_i))
    else $error("request taken during table clear");

  // cells start at one: a grant is positive, a reject is all ones
  a_rsp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_addr_i != 32'd0) && (!rsp_addr_i[31] || (&rsp_addr_i)))
    else $error("result address out of range");

endmodule

bind best_fit_allocator_coalescing bfa_checker u_bfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_addr_i  (rsp_o.start_address)
);

`default_nettype wire
